### rtl/dbsg_pkg.sv
// Shared types, codes and reset values for the drive burst stall guard.
// No dependencies; used by every module in rtl/.
package dbsg_pkg;

  localparam int CURRENT_BITS_DEFAULT = 12;
  localparam int CMD_BITS             = 2;
  localparam int CFG_ADDR_BITS        = 3;
  localparam int CFG_DATA_BITS        = 16;
  localparam int M_TDATA_BITS         = 40;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK  = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_BACK  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MOTION_STOP = 2'd0,
    MOTION_FWD  = 2'd1,
    MOTION_BACK = 2'd2
  } motion_t;

  typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_MAX_PWM        = 3'd0;
  localparam cfg_addr_t REG_MAX_BURST_MS   = 3'd1;
  localparam cfg_addr_t REG_FRONT_THRESH   = 3'd2;
  localparam cfg_addr_t REG_REAR_THRESH    = 3'd3;
  localparam cfg_addr_t REG_DETECT_TIME    = 3'd4;
  localparam cfg_addr_t REG_COOLDOWN_TIME  = 3'd5;
  localparam cfg_addr_t REG_RETRY_LIMIT    = 3'd6;

  localparam logic [7:0]  RST_MAX_PWM       = 8'd255;
  localparam logic [15:0] RST_MAX_BURST_MS  = 16'd0;
  localparam logic [15:0] RST_DETECT_TIME   = 16'd200;
  localparam logic [15:0] RST_COOLDOWN_TIME = 16'd1000;
  localparam logic [7:0]  RST_RETRY_LIMIT   = 8'd3;

  // burst length cap used when max_burst_ms is zero
  localparam logic [15:0] DEFAULT_GUARD_MS  = 16'd60000;

  localparam logic [7:0]  TRIPS_MAX         = 8'hFF;
  localparam logic [15:0] ELAPSED_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  max_pwm;
    logic [15:0] max_burst_ms;
    logic [15:0] detect_time;
    logic [15:0] cooldown_time;
    logic [7:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic        detecting;
    logic [15:0] detect_elapsed;
    logic        trip;
    logic [7:0]  trips;
    logic [15:0] cooldown_left;
  } axle_t;

  localparam axle_t AXLE_CLEAR = '{
    detecting:      1'b0,
    detect_elapsed: 16'd0,
    trip:           1'b0,
    trips:          8'd0,
    cooldown_left:  16'd0
  };

endpackage

### rtl/dbsg_cfg.sv
// Configuration register file for the drive burst stall guard.
// Depends on dbsg_pkg.
module dbsg_cfg #(
  parameter int CURRENT_BITS = dbsg_pkg::CURRENT_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  dbsg_pkg::cfg_addr_t                  cfg_addr,
  input  logic [dbsg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output dbsg_pkg::cfg_t                       cfg,
  output logic [CURRENT_BITS-1:0]              front_thresh,
  output logic [CURRENT_BITS-1:0]              rear_thresh
);
  import dbsg_pkg::*;

  logic cfg_we;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_pwm       <= RST_MAX_PWM;
      cfg.max_burst_ms  <= RST_MAX_BURST_MS;
      cfg.detect_time   <= RST_DETECT_TIME;
      cfg.cooldown_time <= RST_COOLDOWN_TIME;
      cfg.retry_limit   <= RST_RETRY_LIMIT;
      front_thresh      <= {CURRENT_BITS{1'b1}};
      rear_thresh       <= {CURRENT_BITS{1'b1}};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_PWM:       cfg.max_pwm       <= cfg_data[7:0];
        REG_MAX_BURST_MS:  cfg.max_burst_ms  <= cfg_data;
        REG_FRONT_THRESH:  front_thresh      <= cfg_data[CURRENT_BITS-1:0];
        REG_REAR_THRESH:   rear_thresh       <= cfg_data[CURRENT_BITS-1:0];
        REG_DETECT_TIME:   cfg.detect_time   <= cfg_data;
        REG_COOLDOWN_TIME: cfg.cooldown_time <= cfg_data;
        REG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[7:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

### rtl/dbsg_axle.sv
// One-tick update of an axle's stall guard: detect, trip, cooldown, retry.
// Depends on dbsg_pkg. Purely combinational, instanced once per axle.
module dbsg_axle #(
  parameter int CURRENT_BITS = dbsg_pkg::CURRENT_BITS_DEFAULT
) (
  input  dbsg_pkg::axle_t           st,
  input  dbsg_pkg::cfg_t            cfg,
  input  logic                      active,
  input  logic [CURRENT_BITS-1:0]   sample_a,
  input  logic [CURRENT_BITS-1:0]   sample_b,
  input  logic [CURRENT_BITS-1:0]   thresh,
  output dbsg_pkg::axle_t           st_next
);
  import dbsg_pkg::*;

  logic [CURRENT_BITS-1:0] sample;
  logic [15:0]             cd;
  logic [15:0]             elapsed;

  assign sample = (sample_a > sample_b) ? sample_a : sample_b;
  assign cd     = (st.cooldown_left != 16'd0) ? st.cooldown_left - 16'd1 : 16'd0;

  always_comb begin
    st_next               = st;
    st_next.cooldown_left = cd;
    elapsed               = 16'd0;
    if (!active) begin
      st_next.detecting      = 1'b0;
      st_next.detect_elapsed = 16'd0;
    end else if (st.trip) begin
      // retry once rested, if the trip budget allows
      if (cd == 16'd0 && st.trips <= cfg.retry_limit) begin
        st_next.trip           = 1'b0;
        st_next.detecting      = 1'b0;
        st_next.detect_elapsed = 16'd0;
      end
    end else if (sample >= thresh) begin
      if (st.detecting) begin
        elapsed = (st.detect_elapsed != ELAPSED_MAX) ? st.detect_elapsed + 16'd1
                                                     : st.detect_elapsed;
      end
      st_next.detecting      = 1'b1;
      st_next.detect_elapsed = elapsed;
      if (elapsed >= cfg.detect_time) begin
        st_next.trip           = 1'b1;
        st_next.trips          = (st.trips != TRIPS_MAX) ? st.trips + 8'd1 : st.trips;
        st_next.cooldown_left  = cfg.cooldown_time;
        st_next.detecting      = 1'b0;
        st_next.detect_elapsed = 16'd0;
      end
    end else begin
      st_next.detecting      = 1'b0;
      st_next.detect_elapsed = 16'd0;
    end
  end

endmodule

### rtl/drive_burst_stall_guard.sv
// Top level of the drive burst stall guard: stream ports, input register,
// burst state update and result register. Depends on dbsg_pkg, dbsg_cfg, dbsg_axle.
//
// Timed forward/backward drive bursts for a front and a rear axle, each with its own
// stall guard. Every item on the input stream is a command (kind in s_tuser): a tick
// standing for one millisecond, a forward or backward burst, or stop. Each accepted
// item yields exactly one result item, in order, carrying both axles' drive direction
// and duty, the stall flags, the trip counts and whether a burst runs. One item is
// accepted per clock cycle when the output side keeps up; an item passes through the
// input register and then the result register, and the whole update of one item is
// one pass through the state logic and the two axle guards between those registers.
// Configuration registers are written over the cfg port, which is always ready;
// writes are meant to land while no item is in flight.
module drive_burst_stall_guard #(
  parameter int CURRENT_BITS = dbsg_pkg::CURRENT_BITS_DEFAULT,
  localparam int S_TDATA_BITS = ((24 + 4 * CURRENT_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave side
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata, lowest bit up: pwm_request[7:0], burst_ms[15:0], current_front_left,
  // current_front_right, current_rear_left, current_rear_right (CURRENT_BITS each),
  // zero fill to a whole byte
  input  logic [S_TDATA_BITS-1:0]              s_tdata,
  // s_tuser: cmd[1:0]
  input  logic [dbsg_pkg::CMD_BITS-1:0]        s_tuser,
  // master side
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata, lowest bit up: front_motion[1:0], front_duty[7:0], rear_motion[1:0],
  // rear_duty[7:0], front_stalled, rear_stalled, front_trip_count[7:0],
  // rear_trip_count[7:0], burst_active, one zero fill bit
  output logic [dbsg_pkg::M_TDATA_BITS-1:0]    m_tdata,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  dbsg_pkg::cfg_addr_t                  cfg_addr,
  input  logic [dbsg_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import dbsg_pkg::*;

  // field offsets inside s_tdata
  localparam int PWM_LSB   = 0;
  localparam int BURST_LSB = 8;
  localparam int CFL_LSB   = 24;
  localparam int CFR_LSB   = CFL_LSB + CURRENT_BITS;
  localparam int CRL_LSB   = CFR_LSB + CURRENT_BITS;
  localparam int CRR_LSB   = CRL_LSB + CURRENT_BITS;

  // ---- configuration ----
  cfg_t                    cfg;
  logic [CURRENT_BITS-1:0] front_thresh;
  logic [CURRENT_BITS-1:0] rear_thresh;

  dbsg_cfg #(.CURRENT_BITS(CURRENT_BITS)) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .front_thresh (front_thresh),
    .rear_thresh  (rear_thresh)
  );

  // ---- input register ----
  logic                    in_valid;
  cmd_t                    in_cmd;
  logic [7:0]              in_pwm;
  logic [15:0]             in_burst;
  logic [CURRENT_BITS-1:0] in_cfl;
  logic [CURRENT_BITS-1:0] in_cfr;
  logic [CURRENT_BITS-1:0] in_crl;
  logic [CURRENT_BITS-1:0] in_crr;

  // the held item moves on when the result register is empty or being drained
  logic advance;
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= cmd_t'(s_tuser);
      in_pwm   <= s_tdata[PWM_LSB +: 8];
      in_burst <= s_tdata[BURST_LSB +: 16];
      in_cfl   <= s_tdata[CFL_LSB +: CURRENT_BITS];
      in_cfr   <= s_tdata[CFR_LSB +: CURRENT_BITS];
      in_crl   <= s_tdata[CRL_LSB +: CURRENT_BITS];
      in_crr   <= s_tdata[CRR_LSB +: CURRENT_BITS];
    end
  end

  // ---- burst state ----
  motion_t     drive_mode,   drive_mode_next;
  logic [7:0]  drive_level,  drive_level_next;
  logic [15:0] burst_left,   burst_left_next;
  axle_t       front,        front_next;
  axle_t       rear,         rear_next;
  // motor drive latch: what the axles are actually driven with
  motion_t     front_motion, front_motion_next;
  logic [7:0]  front_duty,   front_duty_next;
  motion_t     rear_motion,  rear_motion_next;
  logic [7:0]  rear_duty,    rear_duty_next;

  axle_t       front_tick;
  axle_t       rear_tick;
  logic        active;
  logic [15:0] burst_dec;
  logic [15:0] guard_ms;
  logic [7:0]  level_capped;
  logic [15:0] burst_capped;

  // a zero drive level leaves the guards disarmed
  assign active = (drive_level != 8'd0);

  dbsg_axle #(.CURRENT_BITS(CURRENT_BITS)) u_front (
    .st       (front),
    .cfg      (cfg),
    .active   (active),
    .sample_a (in_cfl),
    .sample_b (in_cfr),
    .thresh   (front_thresh),
    .st_next  (front_tick)
  );

  dbsg_axle #(.CURRENT_BITS(CURRENT_BITS)) u_rear (
    .st       (rear),
    .cfg      (cfg),
    .active   (active),
    .sample_a (in_crl),
    .sample_b (in_crr),
    .thresh   (rear_thresh),
    .st_next  (rear_tick)
  );

  assign burst_dec    = (burst_left != 16'd0) ? burst_left - 16'd1 : 16'd0;
  assign guard_ms     = (cfg.max_burst_ms != 16'd0) ? cfg.max_burst_ms : DEFAULT_GUARD_MS;
  assign level_capped = (in_pwm > cfg.max_pwm) ? cfg.max_pwm : in_pwm;
  assign burst_capped = (in_burst > guard_ms) ? guard_ms : in_burst;

  always_comb begin
    drive_mode_next   = drive_mode;
    drive_level_next  = drive_level;
    burst_left_next   = burst_left;
    front_next        = front;
    rear_next         = rear;
    front_motion_next = front_motion;
    front_duty_next   = front_duty;
    rear_motion_next  = rear_motion;
    rear_duty_next    = rear_duty;
    unique case (in_cmd)
      CMD_TICK: begin
        // ticks while idle change nothing
        if (drive_mode != MOTION_STOP) begin
          if (burst_dec == 16'd0) begin
            // burst timed out: same as stop
            drive_mode_next   = MOTION_STOP;
            burst_left_next   = 16'd0;
            front_next        = AXLE_CLEAR;
            rear_next         = AXLE_CLEAR;
            front_motion_next = MOTION_STOP;
            front_duty_next   = 8'd0;
            rear_motion_next  = MOTION_STOP;
            rear_duty_next    = 8'd0;
          end else begin
            burst_left_next = burst_dec;
            front_next      = front_tick;
            rear_next       = rear_tick;
            if (front_tick.trip) begin
              front_motion_next = MOTION_STOP;
              front_duty_next   = 8'd0;
            end else begin
              front_motion_next = drive_mode;
              front_duty_next   = drive_level;
            end
            if (rear_tick.trip) begin
              rear_motion_next = MOTION_STOP;
              rear_duty_next   = 8'd0;
            end else begin
              rear_motion_next = drive_mode;
              rear_duty_next   = drive_level;
            end
          end
        end
      end
      CMD_FWD, CMD_BACK: begin
        // a new burst arms the state; the motors follow on the next tick
        drive_mode_next  = (in_cmd == CMD_FWD) ? MOTION_FWD : MOTION_BACK;
        drive_level_next = level_capped;
        burst_left_next  = burst_capped;
        front_next       = AXLE_CLEAR;
        rear_next        = AXLE_CLEAR;
      end
      CMD_STOP: begin
        // drive level is kept across a stop
        drive_mode_next   = MOTION_STOP;
        burst_left_next   = 16'd0;
        front_next        = AXLE_CLEAR;
        rear_next         = AXLE_CLEAR;
        front_motion_next = MOTION_STOP;
        front_duty_next   = 8'd0;
        rear_motion_next  = MOTION_STOP;
        rear_duty_next    = 8'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode   <= MOTION_STOP;
      drive_level  <= 8'd0;
      burst_left   <= 16'd0;
      front        <= AXLE_CLEAR;
      rear         <= AXLE_CLEAR;
      front_motion <= MOTION_STOP;
      front_duty   <= 8'd0;
      rear_motion  <= MOTION_STOP;
      rear_duty    <= 8'd0;
    end else if (advance) begin
      drive_mode   <= drive_mode_next;
      drive_level  <= drive_level_next;
      burst_left   <= burst_left_next;
      front        <= front_next;
      rear         <= rear_next;
      front_motion <= front_motion_next;
      front_duty   <= front_duty_next;
      rear_motion  <= rear_motion_next;
      rear_duty    <= rear_duty_next;
    end
  end

  // ---- result register ----
  logic [M_TDATA_BITS-1:0] result;

  assign result = {
    1'b0,
    (drive_mode_next != MOTION_STOP),
    rear_next.trips,
    front_next.trips,
    rear_next.trip,
    front_next.trip,
    rear_duty_next,
    rear_motion_next,
    front_duty_next,
    front_motion_next
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= result;
    end
  end

endmodule
